FILE: src/asfc_pkg.sv
// ----------------------------------------------------------------------------
// asfc_pkg
// Shared types, constants and G.711 / linear conversion functions for the
// audio sample format converter.
// ----------------------------------------------------------------------------
package asfc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int PIPE_DEPTH = 5;

    typedef enum logic [2:0] {
        ENC_S16 = 3'd0,
        ENC_MU  = 3'd1,
        ENC_A   = 3'd2,
        ENC_S8  = 3'd3,
        ENC_U8  = 3'd4
    } enc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_ENC    = 2'd0,
        CFG_TGT_ENC    = 2'd1,
        CFG_SRC_STEREO = 2'd2,
        CFG_TGT_STEREO = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        enc_t src_enc;
        enc_t tgt_enc;
        logic src_stereo;
        logic tgt_stereo;
    } cfg_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } stage_pair_t;

    localparam logic [13:0] MU_SEG_END [0:7] = '{
        14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
        14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
    };

    localparam logic [11:0] A_SEG_END [0:7] = '{
        12'h01F, 12'h03F, 12'h07F, 12'h0FF,
        12'h1FF, 12'h3FF, 12'h7FF, 12'hFFF
    };

    function automatic enc_t norm_enc(input logic [CFG_DATA_W-1:0] code);
        enc_t e;
        case (code)
            ENC_MU:  e = ENC_MU;
            ENC_A:   e = ENC_A;
            ENC_S8:  e = ENC_S8;
            ENC_U8:  e = ENC_U8;
            default: e = ENC_S16;
        endcase
        return e;
    endfunction

    function automatic logic [SAMPLE_W-1:0] raw_mask(input enc_t e,
                                                     input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] r;
        if (e == ENC_S16) r = raw;
        else              r = {8'h00, raw[7:0]};
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] mu_dec(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]   u;
        logic [SAMPLE_W-1:0] t;
        logic [SAMPLE_W-1:0] r;
        u = ~code;
        t = (SAMPLE_W'({u[3:0], 3'b000}) + 16'd132) << u[6:4];
        if (u[7]) r = 16'd132 - t;
        else      r = t - 16'd132;
        return signed'(r);
    endfunction

    function automatic logic [CODE_W-1:0] mu_enc(input logic signed [SAMPLE_W-1:0] lin);
        logic signed [13:0] q;
        logic [13:0]        v;
        logic [13:0]        sh;
        logic [CODE_W-1:0]  mask;
        logic [3:0]         seg;
        logic [CODE_W-1:0]  r;
        q = 14'(lin >>> 2);
        if (q[13]) begin
            v    = 14'(-q);
            mask = 8'h7F;
        end else begin
            v    = q;
            mask = 8'hFF;
        end
        if (v > 14'd8159) v = 14'd8159;
        v   = v + 14'd33;
        seg = 4'd8;
        for (int s = 7; s >= 0; s--) begin
            if (v <= MU_SEG_END[s]) seg = 4'(s);
        end
        sh = v >> (seg + 4'd1);
        if (seg[3]) r = 8'h7F ^ mask;
        else        r = {1'b0, seg[2:0], sh[3:0]} ^ mask;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] a_dec(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]   a;
        logic [2:0]          seg;
        logic [SAMPLE_W-1:0] t;
        logic [SAMPLE_W-1:0] r;
        a   = code ^ 8'h55;
        seg = a[6:4];
        t   = {8'h00, a[3:0], 4'h0};
        if (seg == 3'd0) begin
            t = t + 16'd8;
        end else begin
            t = t + 16'h0108;
            if (seg > 3'd1) t = t << (seg - 3'd1);
        end
        if (a[7]) r = t;
        else      r = -t;
        return signed'(r);
    endfunction

    function automatic logic [CODE_W-1:0] a_enc(input logic signed [SAMPLE_W-1:0] lin);
        logic signed [12:0] q;
        logic [11:0]        v;
        logic [11:0]        sh;
        logic [CODE_W-1:0]  mask;
        logic [3:0]         seg;
        logic [CODE_W-1:0]  r;
        q = 13'(lin >>> 3);
        if (q[12]) begin
            v    = ~q[11:0];
            mask = 8'h55;
        end else begin
            v    = q[11:0];
            mask = 8'hD5;
        end
        seg = 4'd8;
        for (int s = 7; s >= 0; s--) begin
            if (v <= A_SEG_END[s]) seg = 4'(s);
        end
        if (seg < 4'd2) sh = v >> 1;
        else            sh = v >> seg;
        if (seg[3]) r = 8'h7F ^ mask;
        else        r = {1'b0, seg[2:0], sh[3:0]} ^ mask;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_linear(input enc_t e,
                                                             input logic [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] r;
        case (e)
            ENC_MU:  r = mu_dec(raw[7:0]);
            ENC_A:   r = a_dec(raw[7:0]);
            ENC_S8:  r = signed'({raw[7:0], 8'h00});
            ENC_U8:  r = signed'({~raw[7], raw[6:0], 8'h00});
            default: r = signed'(raw);
        endcase
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] from_linear(input enc_t e,
                                                        input logic signed [SAMPLE_W-1:0] lin);
        logic [SAMPLE_W-1:0] r;
        case (e)
            ENC_MU:  r = {8'h00, mu_enc(lin)};
            ENC_A:   r = {8'h00, a_enc(lin)};
            ENC_S8:  r = {8'h00, lin[15:8]};
            ENC_U8:  r = {8'h00, ~lin[15], lin[14:8]};
            default: r = lin;
        endcase
        return r;
    endfunction

endpackage

FILE: src/audio_sample_format_converter_unit.sv
// ----------------------------------------------------------------------------
// audio_sample_format_converter_unit
// Datapath: an input request reaches the output through the channel stage
//   (2), the two conversion lanes (2) and the output register (1).
// Throughput: one frame per cycle; each stage holds under backpressure.
// Reset: synchronous active-low aresetn clears all stage valids and sets the
//   configuration to 16-bit signed mono in and out.
// ----------------------------------------------------------------------------
module audio_sample_format_converter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*asfc_pkg::SAMPLE_W-1:0]   s_tdata,   // first_sample, second_sample
    input  logic                              s_tlast,   // block_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*asfc_pkg::SAMPLE_W-1:0]   m_tdata,   // out_first, out_second
    output logic                              m_tlast,   // out_block_end
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [asfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import asfc_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [PIPE_DEPTH-1:0] stage_ready;
    logic [PIPE_DEPTH-2:0] last_reg;
    stage_pair_t           chan_ctrl, lane_ctrl;
    logic [SAMPLE_W-1:0]   code_first, code_second;
    logic [SAMPLE_W-1:0]   lane_first, lane_second;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SRC_ENC:    cfg_next.src_enc    = norm_enc(cfg_data);
                CFG_TGT_ENC:    cfg_next.tgt_enc    = norm_enc(cfg_data);
                CFG_SRC_STEREO: cfg_next.src_stereo = cfg_data[0];
                CFG_TGT_STEREO: cfg_next.tgt_stereo = cfg_data[0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{src_enc: ENC_S16, tgt_enc: ENC_S16, src_stereo: 1'b0,
                         tgt_stereo: 1'b0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        stage_ready[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next[0] = stage_ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) last_reg[0] <= s_tlast;
        for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
            if (stage_ready[i]) last_reg[i] <= last_reg[i-1];
        end
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    assign chan_ctrl = '{load_a: stage_ready[0], load_b: stage_ready[1]};
    assign lane_ctrl = '{load_a: stage_ready[2], load_b: stage_ready[3]};

    asfc_chan u_chan (
        .aclk          (aclk),
        .ctrl          (chan_ctrl),
        .cfg           (cfg_reg),
        .first_sample  (s_tdata[SAMPLE_W-1:0]),
        .second_sample (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .code_first    (code_first),
        .code_second   (code_second)
    );

    asfc_lane u_lane_first (
        .aclk     (aclk),
        .ctrl     (lane_ctrl),
        .cfg      (cfg_reg),
        .code_in  (code_first),
        .code_out (lane_first)
    );

    asfc_lane u_lane_second (
        .aclk     (aclk),
        .ctrl     (lane_ctrl),
        .cfg      (cfg_reg),
        .code_in  (code_second),
        .code_out (lane_second)
    );

    asfc_merge u_merge (
        .aclk        (aclk),
        .load        (stage_ready[PIPE_DEPTH-1]),
        .tgt_stereo  (cfg_reg.tgt_stereo),
        .lane_first  (lane_first),
        .lane_second (lane_second),
        .last_in     (last_reg[PIPE_DEPTH-2]),
        .frame_data  (m_tdata),
        .frame_last  (m_tlast)
    );

endmodule

FILE: src/asfc_chan.sv
// ----------------------------------------------------------------------------
// asfc_chan
// Channel change stage: masks the source codes, decodes them for averaging,
// and forms the two channel codes in the source encoding (two registers deep).
// ----------------------------------------------------------------------------
module asfc_chan (
    input  logic                          aclk,
    input  asfc_pkg::stage_pair_t         ctrl,
    input  asfc_pkg::cfg_t                cfg,
    input  logic [asfc_pkg::SAMPLE_W-1:0] first_sample,
    input  logic [asfc_pkg::SAMPLE_W-1:0] second_sample,
    output logic [asfc_pkg::SAMPLE_W-1:0] code_first,
    output logic [asfc_pkg::SAMPLE_W-1:0] code_second
);
    import asfc_pkg::*;

    logic [SAMPLE_W-1:0]        x_reg, y_reg;
    logic signed [SAMPLE_W-1:0] dx_reg, dy_reg;
    logic signed [SAMPLE_W-1:0] dx_next, dy_next;
    logic [SAMPLE_W-1:0]        c0_reg, c1_reg, c0_next, c1_next;
    logic [SAMPLE_W-1:0]        avg;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W:0]   half;
    logic signed [8:0]          hx, hy;
    logic [8:0]                 s8_sum;

    always_comb begin
        case (cfg.src_enc)
            ENC_MU: begin
                dx_next = mu_dec(first_sample[7:0]);
                dy_next = mu_dec(second_sample[7:0]);
            end
            ENC_A: begin
                dx_next = a_dec(first_sample[7:0]);
                dy_next = a_dec(second_sample[7:0]);
            end
            default: begin
                dx_next = signed'(first_sample);
                dy_next = signed'(second_sample);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_a) begin
            x_reg  <= raw_mask(cfg.src_enc, first_sample);
            y_reg  <= raw_mask(cfg.src_enc, second_sample);
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    always_comb begin
        sum    = (SAMPLE_W+1)'(dx_reg) + (SAMPLE_W+1)'(dy_reg);
        half   = (sum + (SAMPLE_W+1)'({1'b0, sum[SAMPLE_W]})) >>> 1;
        hx     = (9'(signed'(x_reg[7:0])) + 9'({1'b0, x_reg[7]})) >>> 1;
        hy     = (9'(signed'(y_reg[7:0])) + 9'({1'b0, y_reg[7]})) >>> 1;
        s8_sum = hx + hy;
        case (cfg.src_enc)
            ENC_MU:  avg = {8'h00, mu_enc(half[SAMPLE_W-1:0])};
            ENC_A:   avg = {8'h00, a_enc(half[SAMPLE_W-1:0])};
            ENC_S8:  avg = {8'h00, s8_sum[7:0]};
            ENC_U8:  avg = {8'h00, 8'({1'b0, x_reg[7:1]}) + 8'({1'b0, y_reg[7:1]})};
            default: avg = half[SAMPLE_W-1:0];
        endcase
        if (cfg.src_stereo == cfg.tgt_stereo) begin
            c0_next = x_reg;
            c1_next = y_reg;
        end else if (cfg.tgt_stereo) begin
            c0_next = x_reg;
            c1_next = x_reg;
        end else begin
            c0_next = avg;
            c1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_b) begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
        end
    end

    assign code_first  = c0_reg;
    assign code_second = c1_reg;

endmodule

FILE: src/asfc_lane.sv
// ----------------------------------------------------------------------------
// asfc_lane
// One conversion lane: decodes a channel code to linear, then encodes it in
// the destination format, or passes it when both encodings match.
// ----------------------------------------------------------------------------
module asfc_lane (
    input  logic                          aclk,
    input  asfc_pkg::stage_pair_t         ctrl,
    input  asfc_pkg::cfg_t                cfg,
    input  logic [asfc_pkg::SAMPLE_W-1:0] code_in,
    output logic [asfc_pkg::SAMPLE_W-1:0] code_out
);
    import asfc_pkg::*;

    logic [SAMPLE_W-1:0]        raw_reg;
    logic signed [SAMPLE_W-1:0] lin_reg;
    logic [SAMPLE_W-1:0]        out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (ctrl.load_a) begin
            raw_reg <= code_in;
            lin_reg <= to_linear(cfg.src_enc, code_in);
        end
    end

    always_comb begin
        if (cfg.src_enc == cfg.tgt_enc) out_next = raw_reg;
        else                            out_next = from_linear(cfg.tgt_enc, lin_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_b) begin
            out_reg <= out_next;
        end
    end

    assign code_out = out_reg;

endmodule

FILE: src/asfc_merge.sv
// ----------------------------------------------------------------------------
// asfc_merge
// Output stage: combines both lane results and the frame marker into one
// destination frame, clearing the second sample for a mono destination.
// ----------------------------------------------------------------------------
module asfc_merge (
    input  logic                            aclk,
    input  logic                            load,
    input  logic                            tgt_stereo,
    input  logic [asfc_pkg::SAMPLE_W-1:0]   lane_first,
    input  logic [asfc_pkg::SAMPLE_W-1:0]   lane_second,
    input  logic                            last_in,
    output logic [2*asfc_pkg::SAMPLE_W-1:0] frame_data,
    output logic                            frame_last
);
    import asfc_pkg::*;

    logic [2*SAMPLE_W-1:0] data_reg, data_next;
    logic                  last_reg;

    always_comb begin
        data_next = {tgt_stereo ? lane_second : {SAMPLE_W{1'b0}}, lane_first};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            last_reg <= last_in;
        end
    end

    assign frame_data = data_reg;
    assign frame_last = last_reg;

endmodule

FILE: src/asfc_checker.sv
// ----------------------------------------------------------------------------
// asfc_checker
// Port-level checks for the converter: output hold under backpressure,
// request accounting against the pipeline depth, and reset behavior.
// ----------------------------------------------------------------------------
module asfc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [2*asfc_pkg::SAMPLE_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import asfc_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cnt_reg != '0)
        else $error("output request without a pending input request");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == CNT_W'(PIPE_DEPTH) && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind audio_sample_format_converter_unit asfc_checker u_asfc_checker (.*);
